@@ sv/md5_message_digest_assert.svh @@
// Assertion macros for the MD5 block.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH
// Implication checked every clock, off during reset.
`define MD5_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MD5_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/md5_pkg.sv @@
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] PAD_BYTE = 32'h00000080;
    localparam int unsigned ROUNDS = 64;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_ADD   = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_CHECK = 6'b100000
    } state_t;

    typedef logic [31:0] word_t;

    // round engine control
    typedef struct packed {
        logic       start;
        logic [5:0] round;
    } rnd_ctl_t;

    function automatic logic [31:0] sine_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index for a round
    function automatic logic [3:0] word_pick(input logic [5:0] r);
        logic [3:0] p;
        case (r[5:4])
            2'd0: p = r[3:0];
            2'd1: p = 4'(({2'b0, r[3:0]} << 2) + {2'b0, r[3:0]} + 6'd1);
            2'd2: p = 4'(({2'b0, r[3:0]} << 1) + {2'b0, r[3:0]} + 6'd5);
            default: p = 4'(({2'b0, r[3:0]} << 3) - {2'b0, r[3:0]});
        endcase
        return p;
    endfunction

endpackage

@@ sv/md5_round.sv @@
// One MD5 round per cycle while step is high, on the working registers.
module md5_round (
    input  logic                aclk,
    input  md5_pkg::rnd_ctl_t   ctl,
    input  logic                step,
    input  md5_pkg::word_t      init_a,
    input  md5_pkg::word_t      init_b,
    input  md5_pkg::word_t      init_c,
    input  md5_pkg::word_t      init_d,
    input  md5_pkg::word_t      msg_word,
    output md5_pkg::word_t      a_out,
    output md5_pkg::word_t      b_out,
    output md5_pkg::word_t      c_out,
    output md5_pkg::word_t      d_out
);
    md5_pkg::word_t a_reg, b_reg, c_reg, d_reg;
    md5_pkg::word_t mix, sum, rot;
    logic [4:0] sh;

    always_comb begin
        case (ctl.round[5:4])
            2'd0: mix = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: mix = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: mix = b_reg ^ c_reg ^ d_reg;
            default: mix = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum = a_reg + mix + msg_word + md5_pkg::sine_const(ctl.round);
        sh  = md5_pkg::rot_amount(ctl.round);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            a_reg <= init_a;
            b_reg <= init_b;
            c_reg <= init_c;
            d_reg <= init_d;
        end else if (step) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

    assign a_out = a_reg;
    assign b_out = b_reg;
    assign c_out = c_reg;
    assign d_out = d_reg;
endmodule

@@ sv/md5_message_digest.sv @@
// Input: a word that fills a block holds s_ready low after it is taken, through
//   the 64 rounds, a chain add and a check; a word that is neither last nor the
//   last of a block leaves s_ready high. A last word pads through one or two more
//   blocks, then shows four digest words, one per accepted m_ handshake.
// Blocks: the single round unit hashes one block at a time and takes no new word
//   until that block is through.
// Reset: synchronous active-low aresetn restores the initial chain, zero count.
`include "md5_message_digest_assert.svh"
module md5_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_final_word
);
    md5_pkg::state_t state_reg, state_next;
    md5_pkg::word_t  blk_mem [16];     // message block, written one word a cycle on each push
    md5_pkg::word_t  chain_reg [4];
    logic [63:0] bytes_reg;
    logic [3:0]  fill_reg;
    logic [5:0]  round_reg;
    logic        pad_reg;      // padding in progress
    logic        len_reg;      // length words still owed
    logic        extra_reg;    // 0x80 still owed to the next word
    logic [1:0]  idx_reg;
    md5_pkg::word_t msg_word;
    md5_pkg::word_t wa, wb, wc, wd;
    md5_pkg::rnd_ctl_t ctl;
    logic        push;
    md5_pkg::word_t push_data;
    logic [63:0] bits;
    // word slot of the 0x80 pad in this block
    logic [3:0]  pad_blk_start_reg;

    // length still owed after closing a pad block: true unless length landed here
    function automatic logic len_hold(input logic ex);
        len_hold = ex || (pad_blk_start_reg >= 4'd14);
    endfunction

    assign ctl.start = push && (fill_reg == 4'd15);
    assign ctl.round = round_reg;
    assign bits = bytes_reg << 3;

    // registered block read at the round-ahead address
    always_ff @(posedge aclk) begin
        msg_word <= blk_mem[md5_pkg::word_pick(ctl.start ? 6'd0 : 6'(round_reg + 6'd1))];
        if (push)
            blk_mem[fill_reg] <= push_data;
    end

    md5_round u_round (
        .aclk(aclk), .ctl(ctl), .step(state_reg == md5_pkg::ST_ROUND),
        .init_a(chain_reg[0]), .init_b(chain_reg[1]),
        .init_c(chain_reg[2]), .init_d(chain_reg[3]),
        .msg_word(msg_word),
        .a_out(wa), .b_out(wb), .c_out(wc), .d_out(wd)
    );

    logic [2:0]  cnt;
    logic [31:0] keep;
    always_comb begin
        cnt  = (s_byte_count > 3'd4) ? 3'd4 : s_byte_count;
        keep = (cnt == 3'd0) ? 32'h0 : (32'hFFFFFFFF >> (6'd32 - {cnt, 3'b000}));
        push = 1'b0;
        push_data = s_data_word;
        state_next = state_reg;
        case (state_reg)
            md5_pkg::ST_IDLE: begin
                if (s_valid) begin
                    push = 1'b1;
                    if (s_last_item && cnt != 3'd4)
                        push_data = (s_data_word & keep) |
                                    (md5_pkg::PAD_BYTE << {cnt, 3'b000});
                    if (fill_reg == 4'd15)
                        state_next = md5_pkg::ST_ROUND;
                    else if (s_last_item)
                        state_next = md5_pkg::ST_PAD;
                end
            end
            md5_pkg::ST_PAD: begin
                push = 1'b1;
                if (extra_reg)
                    push_data = md5_pkg::PAD_BYTE;
                else if (len_reg && fill_reg == 4'd14)
                    push_data = bits[31:0];
                else if (len_reg && fill_reg == 4'd15 && !len_hold(1'b0))
                    push_data = bits[63:32];
                else
                    push_data = 32'h0;
                if (fill_reg == 4'd15)
                    state_next = md5_pkg::ST_ROUND;
            end
            md5_pkg::ST_ROUND:
                if (round_reg == 6'(md5_pkg::ROUNDS - 1)) state_next = md5_pkg::ST_ADD;
            md5_pkg::ST_ADD:
                state_next = md5_pkg::ST_CHECK;
            md5_pkg::ST_CHECK:
                state_next = !pad_reg ? md5_pkg::ST_IDLE
                           : (len_reg ? md5_pkg::ST_PAD : md5_pkg::ST_EMIT);
            md5_pkg::ST_EMIT:
                if (m_ready && idx_reg == 2'd3) state_next = md5_pkg::ST_IDLE;
            default: state_next = md5_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            pad_blk_start_reg <= 4'd0;
        else if (state_reg == md5_pkg::ST_IDLE && s_valid && s_last_item)
            pad_blk_start_reg <= (cnt == 3'd4) ? 4'(fill_reg + 4'd1) : fill_reg;
        else if (state_reg == md5_pkg::ST_CHECK)
            pad_blk_start_reg <= 4'd0;
    end

    assign s_ready = (state_reg == md5_pkg::ST_IDLE);
    assign m_valid = (state_reg == md5_pkg::ST_EMIT);
    assign m_digest_word = chain_reg[idx_reg];
    assign m_word_index = idx_reg;
    assign m_final_word = (idx_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= md5_pkg::ST_IDLE;
            chain_reg[0] <= md5_pkg::INIT_A;
            chain_reg[1] <= md5_pkg::INIT_B;
            chain_reg[2] <= md5_pkg::INIT_C;
            chain_reg[3] <= md5_pkg::INIT_D;
            bytes_reg <= 64'd0;
            fill_reg <= 4'd0;
            round_reg <= 6'd0;
            pad_reg <= 1'b0;
            len_reg <= 1'b0;
            extra_reg <= 1'b0;
            idx_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            if (push)
                fill_reg <= fill_reg + 4'd1;
            if (state_reg == md5_pkg::ST_IDLE && s_valid) begin
                bytes_reg <= bytes_reg + (s_last_item ? {61'd0, cnt} : 64'd4);
                if (s_last_item) begin
                    pad_reg <= 1'b1;
                    len_reg <= 1'b1;
                    extra_reg <= (cnt == 3'd4);
                end
            end
            if (state_reg == md5_pkg::ST_PAD)
                extra_reg <= 1'b0;
            // a block whose padding started at word 14 or 15 cannot hold the length
            if (push && fill_reg == 4'd15 && state_reg == md5_pkg::ST_PAD)
                len_reg <= len_hold(extra_reg);
            if (state_reg == md5_pkg::ST_ROUND)
                round_reg <= round_reg + 6'd1;
            if (state_reg == md5_pkg::ST_ADD) begin
                round_reg <= 6'd0;
                chain_reg[0] <= chain_reg[0] + wa;
                chain_reg[1] <= chain_reg[1] + wb;
                chain_reg[2] <= chain_reg[2] + wc;
                chain_reg[3] <= chain_reg[3] + wd;
            end
            if (state_reg == md5_pkg::ST_EMIT && m_ready) begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    chain_reg[0] <= md5_pkg::INIT_A;
                    chain_reg[1] <= md5_pkg::INIT_B;
                    chain_reg[2] <= md5_pkg::INIT_C;
                    chain_reg[3] <= md5_pkg::INIT_D;
                    bytes_reg <= 64'd0;
                    pad_reg <= 1'b0;
                    len_reg <= 1'b0;
                end
            end
        end
    end

    `MD5_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, !m_valid, "ready while emitting")
    `MD5_ASSERT_NEXT(a_idx_step, aclk, aresetn, m_valid && m_ready && !m_final_word,
        m_valid, "digest run broke early")
    `MD5_ASSERT_NEXT(a_emit_done, aclk, aresetn, m_valid && m_ready && m_final_word,
        s_ready && m_word_index == 2'd0, "no return to idle after digest")
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

    // ---------------------------------------------------------------
    // clock and reset
    // ---------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #4 aclk = ~aclk;

    // DUT ports
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word = '0;
    logic [2:0]  s_byte_count = '0;
    logic        s_last_item = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [1:0]  m_word_index;
    logic        m_final_word;

    md5_message_digest u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_word(s_data_word), .s_byte_count(s_byte_count),
        .s_last_item(s_last_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_digest_word(m_digest_word), .m_word_index(m_word_index),
        .m_final_word(m_final_word)
    );

    // one input word as queued for the driver
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
        logic        sync;   // sender waits until all digests are out first
    } msg_word_t;

    typedef struct packed {
        logic [31:0] digest;
        logic [1:0]  idx;
        logic        fin;
    } digest_word_t;

    msg_word_t    word_q[$];
    digest_word_t digest_q[$];
    int           err_cnt = 0;
    int           msg_cnt = 0;
    int           dig_cnt = 0;
    int           acc_cnt = 0;
    bit           stim_done = 1'b0;

    // ---------------------------------------------------------------
    // hash predictor: own copy of the chain, block buffer and length
    // ---------------------------------------------------------------
    logic [31:0] hp_chain[4];
    logic [31:0] hp_blk[16];
    logic [63:0] hp_bytes;
    int          hp_fill;

    logic [31:0] sine_tab[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    int rot_tab[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    function automatic logic [31:0] rotl(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic hash_reset();
        hp_chain = '{md5_pkg::INIT_A, md5_pkg::INIT_B, md5_pkg::INIT_C, md5_pkg::INIT_D};
        hp_bytes = '0;
        hp_fill  = 0;
    endtask

    task automatic hash_compress();
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = hp_chain[0]; b = hp_chain[1]; c = hp_chain[2]; d = hp_chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = 5 * r + 1; end
                2: begin f = b ^ c ^ d;          g = 3 * r + 5; end
                default: begin f = c ^ (b | ~d); g = 7 * r; end
            endcase
            t = a + f + hp_blk[g % 16] + sine_tab[r];
            a = d; d = c; c = b;
            b = b + rotl(t, rot_tab[(r / 16) * 4 + r % 4]);
        end
        hp_chain[0] += a; hp_chain[1] += b; hp_chain[2] += c; hp_chain[3] += d;
    endtask

    task automatic hash_push(logic [31:0] w);
        hp_blk[hp_fill] = w;
        hp_fill++;
        if (hp_fill == 16) begin
            hash_compress();
            hp_fill = 0;
        end
    endtask

    // fold one accepted word into the hash; queue digests on the last one
    task automatic hash_word(msg_word_t w);
        int n;
        logic [31:0] keep;
        logic [63:0] bits;
        if (!w.last) begin
            hp_bytes += 4;
            hash_push(w.data);
            return;
        end
        n = (w.cnt > 4) ? 4 : w.cnt;
        hp_bytes += n;
        if (n == 4) begin
            hash_push(w.data);
            hash_push(md5_pkg::PAD_BYTE);
        end else begin
            keep = (n == 0) ? 32'h0 : (32'hFFFFFFFF >> (32 - 8 * n));
            hash_push((w.data & keep) | (md5_pkg::PAD_BYTE << (8 * n)));
        end
        if (hp_fill > 14)
            while (hp_fill != 0) hash_push(32'h0);
        while (hp_fill < 14) hash_push(32'h0);
        bits = hp_bytes << 3;
        hash_push(bits[31:0]);
        hash_push(bits[63:32]);
        for (int k = 0; k < 4; k++)
            digest_q.push_back('{hp_chain[k], 2'(k), k == 3});
        hash_reset();
    endtask

    // ---------------------------------------------------------------
    // stimulus builders
    // ---------------------------------------------------------------
    function automatic logic [31:0] rnd_data();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // a message of nfull full words then a last word with tail bytes;
    // body words sometimes carry a junk byte count (ignored when not last)
    task automatic add_msg(int nfull, int tail, bit sync);
        for (int i = 0; i < nfull; i++)
            word_q.push_back('{rnd_data(), ($urandom_range(0, 3) == 0) ?
                               3'($urandom_range(0, 7)) : 3'd4, 1'b0, 1'b0});
        word_q.push_back('{rnd_data(), 3'(tail), 1'b1, sync});
    endtask

    // ---------------------------------------------------------------
    // driver: one word in flight, random gaps, optional drain sync
    // ---------------------------------------------------------------
    int gap_cnt = 0;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge aclk) begin
        msg_word_t w;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                hash_word('{s_data_word, s_byte_count, s_last_item, 1'b0});
                acc_cnt++;
                gap_cnt <= pick_gap();
                // on a coin flip, take next word straight away unless it waits for a drain sync
                if (word_q.size() != 0 && !word_q[0].sync && $urandom_range(0, 1)) begin
                    w = word_q.pop_front();
                    s_data_word  <= w.data;
                    s_byte_count <= w.cnt;
                    s_last_item  <= w.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (gap_cnt > 0) begin
                    gap_cnt <= gap_cnt - 1;
                end else if (word_q.size() != 0 &&
                             (!word_q[0].sync || digest_q.size() == 0)) begin
                    w = word_q.pop_front();
                    s_valid      <= 1'b1;
                    s_data_word  <= w.data;
                    s_byte_count <= w.cnt;
                    s_last_item  <= w.last;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random ready, one long hold-off, field compare
    // ---------------------------------------------------------------
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    task automatic report(string what, logic [31:0] got, logic [31:0] exp);
        err_cnt++;
        if (err_cnt <= 30)
            $display("tb_top: mismatch %s got %h exp %h (digest word %0d)",
                     what, got, exp, dig_cnt);
    endtask

    always @(posedge aclk) begin
        digest_word_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    report("unexpected word", m_digest_word, 32'h0);
                end else begin
                    e = digest_q.pop_front();
                    if (m_digest_word !== e.digest) report("digest", m_digest_word, e.digest);
                    if (m_word_index !== e.idx)
                        report("index", 32'(m_word_index), 32'(e.idx));
                    if (m_final_word !== e.fin)
                        report("final", 32'(m_final_word), 32'(e.fin));
                end
                dig_cnt++;
            end
            // long stall once, after more than 150 words have gone in
            if (!hold_done && acc_cnt > 150) begin
                hold_done <= 1'b1;
                hold_cnt  <= 2000;
                m_ready   <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready  <= 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0: hold_cnt <= $urandom_range(10, 80);
                    1, 2, 3, 4: m_ready <= 1'b0;
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        int n;
        hash_reset();
        // directed: empty message, every tail length, junk counts, pad spill
        add_msg(0, 0, 1'b0);
        for (int t = 1; t <= 4; t++) add_msg(0, t, 1'b0);
        add_msg(0, 7, 1'b0);           // count above four
        add_msg(0, 5, 1'b0);
        add_msg(13, 3, 1'b0);          // 0x80 in word 13, length still fits
        add_msg(13, 4, 1'b1);          // pad word spills, drain first
        add_msg(14, 0, 1'b0);          // pad lands in word 14 -> extra block
        msg_cnt = 10;
        // random: mostly short messages, occasionally a long one
        while (word_q.size() < 420) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
            add_msg(n, $urandom_range(0, 7), $urandom_range(0, 24) == 0);
            msg_cnt++;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(word_q.size() == 0 && !s_valid && digest_q.size() == 0))
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("tb_top: %0d messages, %0d words in, %0d digest words out",
                 msg_cnt, acc_cnt, dig_cnt);
        $display("tb_top: covered empty message, all tail sizes, pad spill, long stall");
        if (err_cnt == 0 && digest_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
